FILE: rtl/fqs_pkg.sv
// Shared types, constants and helpers for the FIFO queue with search and remove.
// No dependencies; imported by the top level and the testbench.
package fqs_pkg;

  localparam int DEPTH   = 16;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int FUNC_W  = 3;
  localparam int POS_W   = 4;
  localparam int FOUND_W = 5;
  localparam int STAT_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_FIND   = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BADPOS = 2'd3
  } status_t;

  localparam logic signed [FOUND_W-1:0] FOUND_NONE = '1;

  // Ring address of the entry at offset off from the head.
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (ADDR_W+1)'(DEPTH)) begin
      sum = sum - (ADDR_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/fqs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the queue entries.
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fifo_queue_with_search_remove.sv
// Top level of the bounded FIFO queue with search and remove.
// Depends on fqs_pkg (types, constants, slot_of) and fqs_ram (entry store).
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+--------------------------------------
//   in_      | request   | tvalid / tready  | tuser: func; tdata: value, position
//   out_     | result    | tvalid / tready  | tdata: data, found_index, status, count
//
// Timing: enqueue, clear, unused codes, flagged requests, a find on an empty queue
// and a remove of the last entry finish in the accept cycle; dequeue reads the RAM
// on accept and answers from S_DEQ; find steps through S_FIND one entry at a time
// up to the first match; remove moves one entry per cycle in S_RMV. The single RAM
// read port sets this pace. Reset clears head, count, state and the result valid
// flag; entry contents are not cleared and are never read before being written.
// A stalled result register holds the request side off until the result is taken.
module fifo_queue_with_search_remove
  import fqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // [2:0] func
  input  logic [39:0] in_tdata,   // [31:0] value, [35:32] position, [39:36] zero
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [31:0] data, [36:32] found_index,
                                  // [38:37] status, [43:39] count, [47:44] zero
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEQ  = 4'b0010,
    S_FIND = 4'b0100,
    S_RMV  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;

  // result register
  logic                      out_valid_r;
  logic [VALUE_W-1:0]        out_data_r;
  logic signed [FOUND_W-1:0] out_found_r;
  status_t                   out_status_r;
  logic [CNT_W-1:0]          out_count_r;

  logic                      res_load;
  logic [VALUE_W-1:0]        res_data;
  logic signed [FOUND_W-1:0] res_found;
  status_t                   res_status;

  // RAM port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata;

  // request fields
  logic               accept;
  op_t                in_func;
  logic [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]   in_pos;
  logic [CNT_W-1:0]   pos_ext;

  assign in_func  = op_t'(in_tuser);
  assign in_value = in_tdata[VALUE_W-1:0];
  assign in_pos   = in_tdata[VALUE_W +: POS_W];
  assign pos_ext  = CNT_W'(in_pos);

  // Take a request only between operations, and only when the result register
  // is empty or being drained this cycle.
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  fqs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    occ_nxt    = occ_r;
    idx_nxt    = idx_r;
    key_nxt    = key_r;
    res_load   = 1'b0;
    res_data   = '0;
    res_found  = FOUND_NONE;
    res_status = STAT_OK;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            OP_ENQ: begin
              res_load = 1'b1;
              if (occ_r == CNT_W'(DEPTH)) begin
                res_status = STAT_FULL;            // drop the value
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(head_r, occ_r[ADDR_W-1:0]);
                ram_wdata = in_value;
                occ_nxt   = occ_r + 1'b1;
              end
            end
            OP_DEQ: begin
              if (occ_r == '0) begin
                res_load   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                // read the front now, hand the word out next cycle
                ram_raddr = head_r;
                head_nxt  = slot_of(head_r, ADDR_W'(1));
                occ_nxt   = occ_r - 1'b1;
                state_nxt = S_DEQ;
              end
            end
            OP_FIND: begin
              key_nxt = in_value;
              if (occ_r == '0) begin
                res_load = 1'b1;
              end else begin
                ram_raddr = head_r;
                idx_nxt   = '0;
                state_nxt = S_FIND;
              end
            end
            OP_REMOVE: begin
              if (pos_ext >= occ_r) begin
                res_load   = 1'b1;
                res_status = STAT_BADPOS;
              end else if (pos_ext == occ_r - 1'b1) begin
                // last entry: nothing behind it to move up
                res_load = 1'b1;
                occ_nxt  = occ_r - 1'b1;
              end else begin
                ram_raddr = slot_of(head_r, ADDR_W'(in_pos) + 1'b1);
                idx_nxt   = ADDR_W'(in_pos);
                state_nxt = S_RMV;
              end
            end
            OP_CLEAR: begin
              res_load = 1'b1;
              head_nxt = '0;
              occ_nxt  = '0;
            end
            default: begin
              res_load = 1'b1;                     // unused code: no operation
            end
          endcase
        end
      end

      S_DEQ: begin
        res_load  = 1'b1;
        res_data  = ram_rdata;
        state_nxt = S_IDLE;
      end

      S_FIND: begin
        // ram_rdata holds the entry at position idx_r
        if (ram_rdata == key_r) begin
          res_load  = 1'b1;
          res_found = FOUND_W'(idx_r);
          state_nxt = S_IDLE;
        end else if (CNT_W'(idx_r) + 1'b1 == occ_r) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = slot_of(head_r, idx_r + 1'b1);
          idx_nxt   = idx_r + 1'b1;
        end
      end

      S_RMV: begin
        // ram_rdata holds the entry at idx_r + 1; move it up one place
        ram_we    = 1'b1;
        ram_waddr = slot_of(head_r, idx_r);
        ram_wdata = ram_rdata;
        if (CNT_W'(idx_r) + 2'd2 == occ_r) begin
          res_load  = 1'b1;
          occ_nxt   = occ_r - 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = slot_of(head_r, idx_r + 2'd2);
          idx_nxt   = idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    if (res_load) begin
      out_data_r   <= res_data;
      out_found_r  <= res_found;
      out_status_r <= res_status;
      out_count_r  <= occ_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_count_r, out_status_r, out_found_r, out_data_r};

endmodule

FILE: tb/tb_fifo_queue_with_search_remove.sv
// Self-checking testbench for fifo_queue_with_search_remove: directed table, then random requests.
// Depends on fqs_pkg (widths, op_t, status_t, FOUND_NONE) and the block's top level only.
`timescale 1ns / 1ps

module tb_fifo_queue_with_search_remove;
  import fqs_pkg::*;

  // Spare function codes: the block must treat them as a no-operation.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 1720;
  localparam int HOLD_AT         = 300;   // receiver holds off from this request on
  localparam int HOLD_CYCLES     = 300;
  localparam int PAUSE_AT        = 800;   // sender drains all results here
  localparam int STEADY_FROM     = 1100;  // no idling on either side in this window
  localparam int STEADY_TO       = 1400;
  localparam int SETTLE_CYCLES   = 40;    // well beyond the longest find or remove
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int MAX_REPORTS     = 60;

  typedef struct {
    logic signed [VALUE_W-1:0] data;
    logic signed [FOUND_W-1:0] found;
    status_t                   status;
    logic [CNT_W-1:0]          count;
  } queue_result_t;

  // One request as offered; typed rows carry the result read straight off the spec.
  typedef struct {
    bit            typed;
    queue_result_t want;
  } offered_request_t;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    int                 reps;
    bit                 typed;
    queue_result_t      want;
  } stimulus_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [2:0]  in_tuser;   // [2:0] func
  logic [39:0] in_tdata;   // [31:0] value, [35:32] position, [39:36] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [31:0] data, [36:32] found_index, [38:37] status,
                           // [43:39] count, [47:44] zero

  // Shadow copy of the queue, advanced on every accepted request.
  logic [VALUE_W-1:0] model_entries [DEPTH];
  int                 model_head  = 0;
  int                 model_count = 0;

  offered_request_t pending_requests [$];
  queue_result_t    expected_results [$];
  stimulus_row_t    directed_rows    [$];
  queue_result_t    no_typed_result;

  int mismatch_count = 0;
  int results_seen   = 0;
  int stall_cycles   = 0;
  bit steady_run     = 1'b0;
  bit hold_request   = 1'b0;

  fifo_queue_with_search_remove dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int ring_pos(int off);
    return (model_head + off) % DEPTH;
  endfunction

  // Apply one request to the shadow queue and return the result it must produce.
  function automatic queue_result_t predict_queue_op(logic [FUNC_W-1:0] func,
                                                     logic [VALUE_W-1:0] value,
                                                     logic [POS_W-1:0] pos);
    queue_result_t r;
    int            i;
    r.data   = '0;
    r.found  = FOUND_NONE;
    r.status = STAT_OK;
    case (func)
      OP_ENQ: begin
        if (model_count >= DEPTH) begin
          r.status = STAT_FULL;   // drop the value, keep the queue
        end else begin
          model_entries[ring_pos(model_count)] = value;
          model_count++;
        end
      end
      OP_DEQ: begin
        if (model_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.data     = model_entries[model_head];
          model_head = (model_head + 1) % DEPTH;
          model_count--;
        end
      end
      OP_FIND: begin
        // First match from the front wins; only live entries are looked at.
        for (i = 0; i < model_count; i++) begin
          if (model_entries[ring_pos(i)] == value) begin
            r.found = FOUND_W'(i);
            break;
          end
        end
      end
      OP_REMOVE: begin
        if (int'(pos) >= model_count) begin
          r.status = STAT_BADPOS;
        end else begin
          // Close the gap: every later entry moves up one place.
          for (i = int'(pos); i + 1 < model_count; i++) begin
            model_entries[ring_pos(i)] = model_entries[ring_pos(i + 1)];
          end
          model_count--;
        end
      end
      OP_CLEAR: begin
        model_head  = 0;
        model_count = 0;
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(model_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Predict at the request handshake, compare at the result handshake. Both
  // sit in one block so the expectation is always queued before it is needed.
  always @(posedge clk) begin
    queue_result_t    predicted;
    queue_result_t    got;
    queue_result_t    want;
    offered_request_t req;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predicted = predict_queue_op(in_tuser, in_tdata[31:0], in_tdata[35:32]);
        if (pending_requests.size() > 0) begin
          req = pending_requests.pop_front();
          expected_results.push_back(req.typed ? req.want : predicted);
        end else begin
          expected_results.push_back(predicted);
        end
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.data   = out_tdata[31:0];
        got.found  = out_tdata[36:32];
        got.status = status_t'(out_tdata[38:37]);
        got.count  = out_tdata[43:39];
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_results.pop_front();
          if (got.data !== want.data)
            report_mismatch($sformatf("result %0d data %0d, expected %0d",
                                      results_seen, got.data, want.data));
          if (got.found !== want.found)
            report_mismatch($sformatf("result %0d found_index %0d, expected %0d",
                                      results_seen, got.found, want.found));
          if (got.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      results_seen, got.status, want.status));
          if (got.count !== want.count)
            report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                      results_seen, got.count, want.count));
        end
      end
    end
  end

  // Abort when neither channel moves for too long; the receiver hold-off is
  // the longest legal quiet spell and sits well inside the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, stall_cycles);
      $display("tb_fifo_queue_with_search_remove NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;   // hold off so the block fills and stalls its input
      end else begin
        out_tready <= steady_run || ($urandom_range(99) >= 27);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one request, idling first at random, and return at its handshake edge.
  task automatic offer_request(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value,
                               logic [POS_W-1:0] pos, bit typed, queue_result_t want);
    offered_request_t req;
    if (!steady_run && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 27);
    end
    req.typed = typed;
    req.want  = want;
    pending_requests.push_back(req);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {4'b0000, pos, value};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every request has been answered.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_requests.size() > 0 || expected_results.size() > 0);
  endtask

  function automatic stimulus_row_t row(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value,
                                        logic [POS_W-1:0] pos, int reps, bit typed,
                                        logic signed [VALUE_W-1:0] data,
                                        logic signed [FOUND_W-1:0] found,
                                        status_t status, logic [CNT_W-1:0] count);
    stimulus_row_t s;
    s.func        = func;
    s.value       = value;
    s.pos         = pos;
    s.reps        = reps;
    s.typed       = typed;
    s.want.data   = data;
    s.want.found  = found;
    s.want.status = status;
    s.want.count  = count;
    return s;
  endfunction

  // Often values already queued (so finds hit and duplicates appear),
  // then a narrow band, the extremes and fully random words.
  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40 && model_count > 0)
      return model_entries[ring_pos($urandom_range(model_count - 1))];
    if (sel < 60)
      return VALUE_W'(int'($urandom_range(8)) - 4);
    if (sel < 70) begin
      case ($urandom_range(3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  initial begin
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    int                 n;
    int                 k;
    int                 fill_bias;
    int                 enq_share;
    int                 roll;

    foreach (model_entries[i]) model_entries[i] = '0;
    no_typed_result.data   = '0;
    no_typed_result.found  = FOUND_NONE;
    no_typed_result.status = STAT_OK;
    no_typed_result.count  = '0;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= '0;
    in_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: dequeue, find and remove on an empty queue, the value extremes and a find
    // of one, a spare code, a fill to the brim, enqueue when full, remove at the last place and
    // past the end, a find, then dequeue, clear and dequeue on the cleared queue.
    directed_rows.push_back(row(OP_DEQ,    32'h0,         4'd0,  1,  1, 0, FOUND_NONE,
                                STAT_EMPTY,  5'd0));
    directed_rows.push_back(row(OP_FIND,   32'h0,         4'd0,  1,  1, 0, FOUND_NONE,
                                STAT_OK,     5'd0));
    directed_rows.push_back(row(OP_REMOVE, 32'h0,         4'd0,  1,  1, 0, FOUND_NONE,
                                STAT_BADPOS, 5'd0));
    directed_rows.push_back(row(OP_ENQ,    32'h7FFF_FFFF, 4'd0,  1,  1, 0, FOUND_NONE,
                                STAT_OK,     5'd1));
    directed_rows.push_back(row(OP_ENQ,    32'h8000_0000, 4'd15, 1,  1, 0, FOUND_NONE,
                                STAT_OK,     5'd2));
    directed_rows.push_back(row(OP_FIND,   32'h8000_0000, 4'd0,  1,  1, 0, 5'sd1,
                                STAT_OK,     5'd2));
    directed_rows.push_back(row(FUNC_UNUSED_HI, 32'hFFFF_FFFF, 4'd15, 1, 1, 0, FOUND_NONE,
                                STAT_OK,     5'd2));
    directed_rows.push_back(row(OP_ENQ,    32'd100,       4'd0,  14, 0, 0, FOUND_NONE,
                                STAT_OK,     5'd0));
    directed_rows.push_back(row(OP_ENQ,    32'd5,         4'd0,  1,  1, 0, FOUND_NONE,
                                STAT_FULL,   5'd16));
    directed_rows.push_back(row(OP_REMOVE, 32'h0,         4'd15, 1,  0, 0, FOUND_NONE,
                                STAT_OK,     5'd0));
    directed_rows.push_back(row(OP_REMOVE, 32'h0,         4'd15, 1,  1, 0, FOUND_NONE,
                                STAT_BADPOS, 5'd15));
    directed_rows.push_back(row(OP_FIND,   32'd112,       4'd0,  1,  0, 0, FOUND_NONE,
                                STAT_OK,     5'd0));
    directed_rows.push_back(row(OP_DEQ,    32'h0,         4'd0,  1,  1, 32'sh7FFF_FFFF,
                                FOUND_NONE, STAT_OK, 5'd14));
    directed_rows.push_back(row(OP_CLEAR,  32'h0,         4'd0,  1,  1, 0, FOUND_NONE,
                                STAT_OK,     5'd0));
    directed_rows.push_back(row(OP_DEQ,    32'h0,         4'd0,  1,  1, 0, FOUND_NONE,
                                STAT_EMPTY,  5'd0));

    foreach (directed_rows[r]) begin
      for (k = 0; k < directed_rows[r].reps; k++) begin
        offer_request(directed_rows[r].func, directed_rows[r].value + VALUE_W'(k),
                      directed_rows[r].pos, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // Random part: the mix drifts between draining, balanced and filling so
    // the queue spends time empty, half full and full.
    fill_bias = 1;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 150 == 0) fill_bias = $urandom_range(2);
      if (n == HOLD_AT) hold_request = 1'b1;
      if (n == PAUSE_AT) drain_results();
      steady_run = (n >= STEADY_FROM && n < STEADY_TO);

      enq_share = 20 + 20 * fill_bias;
      value     = pick_value();
      pos       = $urandom_range(15);
      if ($urandom_range(99) < enq_share) begin
        func = OP_ENQ;
      end else begin
        roll = $urandom_range(99);
        if (roll < 30) begin
          func = OP_DEQ;
        end else if (roll < 62) begin
          func = OP_FIND;
        end else if (roll < 94) begin
          func = OP_REMOVE;
          // Mostly a live position; the rest may run past the end.
          if (model_count > 0 && $urandom_range(99) < 75)
            pos = POS_W'($urandom_range(model_count - 1));
        end else if (roll < 97) begin
          func = OP_CLEAR;
        end else begin
          func = FUNC_UNUSED_LO + FUNC_W'($urandom_range(2));
        end
      end
      offer_request(func, value, pos, 1'b0, no_typed_result);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (mismatch_count == 0) begin
      $display("tb_fifo_queue_with_search_remove OK");
    end else begin
      $display("tb_fifo_queue_with_search_remove NOT OK");
    end
    $finish;
  end

endmodule

FILE: fifo_queue_with_search_remove.f
rtl/fqs_pkg.sv
rtl/fqs_ram.sv
rtl/fifo_queue_with_search_remove.sv
tb/tb_fifo_queue_with_search_remove.sv
